@@ src/cpps_pkg.sv @@
package cpps_pkg;

  localparam int CW    = 32;
  localparam int GW    = 31;
  localparam int NW    = CW + 1;
  localparam int PW    = CW + 2;
  localparam int DW    = PW + 1;
  localparam int AW    = DW + 1;
  localparam int SW    = 2 * AW;
  localparam int QW    = SW / 2;
  localparam int RW    = QW + 2;
  localparam int EW    = QW + 4;
  localparam int NDIV  = NW;
  localparam int NSQ   = AW;
  localparam int NPAIR = SW / 2;

  localparam logic [GW-1:0] GRID_SP_RST = GW'(65536);
  localparam logic signed [EW-1:0] CMAX = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] CMIN = ~CMAX;

  typedef enum logic [1:0] {
    REG_GRID_ON = 2'd0,
    REG_GRID_SP = 2'd1,
    REG_ORTHO   = 2'd2,
    REG_POLAR   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    DIR_H = 3'b001,
    DIR_V = 3'b010,
    DIR_D = 3'b100
  } dir_t;

  typedef struct packed {
    logic signed [CW-1:0] cursor_x;
    logic signed [CW-1:0] cursor_y;
    logic                 has_object_snap;
    logic signed [CW-1:0] snap_x;
    logic signed [CW-1:0] snap_y;
    logic                 has_last_point;
    logic signed [CW-1:0] last_x;
    logic signed [CW-1:0] last_y;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] result_x;
    logic signed [CW-1:0] result_y;
    logic                 saturated;
  } out_t;

  typedef struct packed {
    logic                 byp;
    logic                 has_last;
    logic signed [CW-1:0] lx;
    logic signed [CW-1:0] ly;
  } ctx_t;

  typedef struct packed {
    ctx_t                 ctx;
    logic                 gen;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic [NW-1:0]        nx;
    logic [NW-1:0]        ny;
    logic [CW-1:0]        rx;
    logic [CW-1:0]        ry;
  } grid_t;

  typedef struct packed {
    ctx_t                 ctx;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic                 sgx;
    logic                 sgy;
    logic                 xdom;
    logic [AW-1:0]        ax;
    logic [AW-1:0]        ay;
    logic [AW-1:0]        as;
    logic [SW-1:0]        accx;
    logic [SW-1:0]        accy;
    logic [SW-1:0]        accs;
  } sq_t;

  typedef struct packed {
    ctx_t                 ctx;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic                 sgx;
    logic                 sgy;
    logic                 xdom;
    dir_t                 dir;
    logic                 odd;
    logic [SW-1:0]        v;
    logic [QW-1:0]        q;
    logic [RW-1:0]        r;
  } rt_t;

endpackage

@@ src/cad_pick_point_snap.sv @@
// Pick point snap: one result per beat, a new beat accepted every cycle unless a stalled result
// holds the pipeline. Each beat runs through a row of 33 divider cells (grid rounding, one
// remainder bit per cell), 36 shift-add cells (squares of the offset) and 36 square-root cells
// (two radicand bits per cell), then an output register. A stalled output holds the whole
// pipeline, so in_stall follows out_stall while a result waits. Write configuration only while
// no beat is in flight.
module cad_pick_point_snap import cpps_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data,
  input  logic          cfg_we,
  input  reg_idx_t      cfg_idx,
  input  logic [GW-1:0] cfg_wdata
);

  logic          grid_on_r;
  logic [GW-1:0] grid_sp_r;
  logic          ortho_r;
  logic          polar_r;

  logic          en;
  logic [CW-1:0] dvs;
  logic [CW-1:0] a0x;
  logic [CW-1:0] a0y;

  logic [NDIV:0]  g_v;
  grid_t          g_d [NDIV+1];
  logic [NSQ:0]   s_v;
  sq_t            s_d [NSQ+1];
  logic [NPAIR:0] r_v;
  rt_t            r_d [NPAIR+1];

  logic [NW-1:0]        dfx;
  logic [NW-1:0]        dfy;
  logic signed [PW-1:0] gpx;
  logic signed [PW-1:0] gpy;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        mx;
  logic [DW-1:0]        my;
  logic [SW-1:0]        ssum;
  logic                 horiz;
  logic                 vert;

  rt_t                  rf;
  logic                 half;
  logic                 up;
  logic [QW:0]          len;
  logic signed [EW-1:0] le;
  logic signed [EW-1:0] ox;
  logic signed [EW-1:0] oy;
  logic signed [EW-1:0] pxe;
  logic signed [EW-1:0] pye;
  logic signed [EW-1:0] lxe;
  logic signed [EW-1:0] lye;
  logic signed [EW-1:0] fx;
  logic signed [EW-1:0] fy;
  logic                 out_valid_r;
  out_t                 out_r;
  out_t                 out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_on_r <= 1'b0;
      grid_sp_r <= GRID_SP_RST;
      ortho_r   <= 1'b0;
      polar_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GRID_ON: grid_on_r <= cfg_wdata[0];
        REG_GRID_SP: grid_sp_r <= cfg_wdata;
        REG_ORTHO:   ortho_r   <= cfg_wdata[0];
        REG_POLAR:   polar_r   <= cfg_wdata[0];
        default:     grid_on_r <= grid_on_r;
      endcase
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign dvs      = {grid_sp_r, 1'b0};

  always_comb begin
    a0x = in_data.cursor_x[CW-1] ? (CW'(0) - $unsigned(in_data.cursor_x))
                                  : $unsigned(in_data.cursor_x);
    a0y = in_data.cursor_y[CW-1] ? (CW'(0) - $unsigned(in_data.cursor_y))
                                  : $unsigned(in_data.cursor_y);
    g_v[0]          = in_valid;
    g_d[0].ctx.byp  = in_data.has_object_snap;
    g_d[0].ctx.has_last = in_data.has_last_point;
    g_d[0].ctx.lx   = in_data.last_x;
    g_d[0].ctx.ly   = in_data.last_y;
    g_d[0].gen      = grid_on_r && (grid_sp_r != '0) && !in_data.has_object_snap;
    g_d[0].neg_x    = in_data.cursor_x[CW-1];
    g_d[0].neg_y    = in_data.cursor_y[CW-1];
    g_d[0].px       = in_data.has_object_snap ? PW'(in_data.snap_x) : PW'(in_data.cursor_x);
    g_d[0].py       = in_data.has_object_snap ? PW'(in_data.snap_y) : PW'(in_data.cursor_y);
    g_d[0].nx       = {a0x, 1'b0} + NW'(grid_sp_r);
    g_d[0].ny       = {a0y, 1'b0} + NW'(grid_sp_r);
    g_d[0].rx       = '0;
    g_d[0].ry       = '0;
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    cpps_div_cell #(.BIT(NDIV - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .dvs   (dvs),
      .vld_i (g_v[k]),
      .d_i   (g_d[k]),
      .vld_o (g_v[k+1]),
      .d_o   (g_d[k+1])
    );
  end

  always_comb begin
    dfx = g_d[NDIV].nx - {1'b0, g_d[NDIV].rx};
    dfy = g_d[NDIV].ny - {1'b0, g_d[NDIV].ry};
    gpx = g_d[NDIV].px;
    gpy = g_d[NDIV].py;
    if (g_d[NDIV].gen) begin
      gpx = g_d[NDIV].neg_x ? -$signed({2'b00, dfx[NW-1:1]}) : $signed({2'b00, dfx[NW-1:1]});
      gpy = g_d[NDIV].neg_y ? -$signed({2'b00, dfy[NW-1:1]}) : $signed({2'b00, dfy[NW-1:1]});
    end
    dx = DW'(gpx) - DW'(g_d[NDIV].ctx.lx);
    dy = DW'(gpy) - DW'(g_d[NDIV].ctx.ly);
    mx = dx[DW-1] ? (DW'(0) - $unsigned(dx)) : $unsigned(dx);
    my = dy[DW-1] ? (DW'(0) - $unsigned(dy)) : $unsigned(dy);
    s_v[0]      = g_v[NDIV];
    s_d[0].ctx  = g_d[NDIV].ctx;
    s_d[0].px   = gpx;
    s_d[0].py   = gpy;
    s_d[0].sgx  = dx[DW-1];
    s_d[0].sgy  = dy[DW-1];
    s_d[0].xdom = mx >= my;
    s_d[0].ax   = AW'(mx);
    s_d[0].ay   = AW'(my);
    s_d[0].as   = AW'(mx) + AW'(my);
    s_d[0].accx = '0;
    s_d[0].accy = '0;
    s_d[0].accs = '0;
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    cpps_sq_cell #(.BIT(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (s_v[k]),
      .d_i   (s_d[k]),
      .vld_o (s_v[k+1]),
      .d_o   (s_d[k+1])
    );
  end

  always_comb begin
    horiz  = {1'b0, s_d[NSQ].accs} < {s_d[NSQ].accx, 1'b0};
    vert   = {1'b0, s_d[NSQ].accs} < {s_d[NSQ].accy, 1'b0};
    ssum   = s_d[NSQ].accx + s_d[NSQ].accy;
    r_v[0]      = s_v[NSQ];
    r_d[0].ctx  = s_d[NSQ].ctx;
    r_d[0].px   = s_d[NSQ].px;
    r_d[0].py   = s_d[NSQ].py;
    r_d[0].sgx  = s_d[NSQ].sgx;
    r_d[0].sgy  = s_d[NSQ].sgy;
    r_d[0].xdom = s_d[NSQ].xdom;
    r_d[0].dir  = horiz ? DIR_H : (vert ? DIR_V : DIR_D);
    r_d[0].odd  = ssum[0];
    r_d[0].v    = (horiz || vert) ? ssum : (ssum >> 1);
    r_d[0].q    = '0;
    r_d[0].r    = '0;
  end

  for (genvar k = 0; k < NPAIR; k++) begin : g_rt
    cpps_sqrt_cell #(.P(NPAIR - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (r_v[k]),
      .d_i   (r_d[k]),
      .vld_o (r_v[k+1]),
      .d_o   (r_d[k+1])
    );
  end

  always_comb begin
    rf   = r_d[NPAIR];
    half = rf.dir == DIR_D;
    up   = (RW'(rf.q) < rf.r) || (half && rf.odd && (RW'(rf.q) == rf.r));
    len  = (QW+1)'(rf.q) + (QW+1)'(up);
    le   = $signed({{(EW-QW-1){1'b0}}, len});
    pxe  = EW'(rf.px);
    pye  = EW'(rf.py);
    lxe  = EW'(rf.ctx.lx);
    lye  = EW'(rf.ctx.ly);
    ox   = (rf.dir == DIR_V) ? '0 : (rf.sgx ? -le : le);
    oy   = (rf.dir == DIR_H) ? '0 : (rf.sgy ? -le : le);
    fx   = pxe;
    fy   = pye;
    priority if (rf.ctx.byp || !rf.ctx.has_last) begin
      fx = pxe;
      fy = pye;
    end else if (ortho_r) begin
      fx = rf.xdom ? pxe : lxe;
      fy = rf.xdom ? lye : pye;
    end else if (polar_r) begin
      fx = lxe + ox;
      fy = lye + oy;
    end
    out_nxt.result_x  = (fx > CMAX) ? CW'(CMAX) : ((fx < CMIN) ? CW'(CMIN) : CW'(fx));
    out_nxt.result_y  = (fy > CMAX) ? CW'(CMAX) : ((fy < CMIN) ? CW'(CMIN) : CW'(fy));
    out_nxt.saturated = (fx > CMAX) || (fx < CMIN) || (fy > CMAX) || (fy < CMIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r_v[NPAIR];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.result_x == CW'(CMAX) || out_data.result_x == CW'(CMIN) ||
       out_data.result_y == CW'(CMAX) || out_data.result_y == CW'(CMIN)))
    else $error("saturated flag without a clamped coordinate");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(r_v)))
    else $error("pipeline advanced under a blocked result");

endmodule

@@ src/cpps_div_cell.sv @@
module cpps_div_cell import cpps_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [CW-1:0] dvs,
  input  logic          vld_i,
  input  grid_t         d_i,
  output logic          vld_o,
  output grid_t         d_o
);

  logic  vld_r;
  grid_t d_r;
  grid_t d_nxt;

  function automatic logic [CW-1:0] rstep(input logic [CW-1:0] r, input logic [NW-1:0] n,
                                          input logic [CW-1:0] d);
    logic [CW:0] t;
    t = {r, n[BIT]};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[CW-1:0];
  endfunction

  always_comb begin
    d_nxt    = d_i;
    d_nxt.rx = rstep(d_i.rx, d_i.nx, dvs);
    d_nxt.ry = rstep(d_i.ry, d_i.ny, dvs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

@@ src/cpps_sq_cell.sv @@
module cpps_sq_cell import cpps_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  sq_t  d_i,
  output logic vld_o,
  output sq_t  d_o
);

  logic vld_r;
  sq_t  d_r;
  sq_t  d_nxt;

  function automatic logic [SW-1:0] pp(input logic [AW-1:0] a);
    return a[BIT] ? (SW'(a) << BIT) : '0;
  endfunction

  always_comb begin
    d_nxt      = d_i;
    d_nxt.accx = d_i.accx + pp(d_i.ax);
    d_nxt.accy = d_i.accy + pp(d_i.ay);
    d_nxt.accs = d_i.accs + pp(d_i.as);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

@@ src/cpps_sqrt_cell.sv @@
module cpps_sqrt_cell import cpps_pkg::*; #(
  parameter int P = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  rt_t  d_i,
  output logic vld_o,
  output rt_t  d_o
);

  logic          vld_r;
  rt_t           d_r;
  rt_t           d_nxt;
  logic [RW+1:0] t;
  logic [RW+1:0] trial;

  always_comb begin
    d_nxt = d_i;
    t     = {d_i.r, d_i.v[2*P+1 -: 2]};
    trial = {2'b00, d_i.q, 2'b01};
    if (t >= trial) begin
      d_nxt.r = RW'(t - trial);
      d_nxt.q = {d_i.q[QW-2:0], 1'b1};
    end else begin
      d_nxt.r = t[RW-1:0];
      d_nxt.q = {d_i.q[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

@@ test/cpps_checker.sv @@
module cpps_checker import cpps_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  in_t           in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  out_t          out_data,
  input  logic          cfg_we,
  input  reg_idx_t      cfg_idx,
  input  logic [GW-1:0] cfg_wdata,
  output int            fails,
  output int            pending,
  output int            beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic          grid_on;
  logic [GW-1:0] grid_sp;
  logic          ortho_on;
  logic          polar_on;
  out_t          expected_pts[$];

  function automatic longint grid_round(longint v, longint g);
    longint a, q, m;
    a = v < 0 ? -v : v;
    q = (2 * a + g) / (2 * g);
    m = q * g;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint root_round(logic [127:0] s, bit half);
    logic [127:0] r, c, sq, t;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (128'd1 << b);
      sq = c * c;
      if (half) sq = sq * 2;
      if (!(s < sq)) r = c;
    end
    t = r * r + r;
    if (half) t = t * 2;
    if (t < s) r = r + 1;
    return longint'(r);
  endfunction

  function automatic longint clamp_coord(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic out_t predict_point(in_t b);
    longint px, py, lx, ly, dx, dy, ox, oy, l;
    logic [127:0] ax, ay, s, sum2, x2, y2;
    bit sat;
    out_t r;
    px = longint'(b.cursor_x);
    py = longint'(b.cursor_y);
    lx = longint'(b.last_x);
    ly = longint'(b.last_y);
    sat = 0;
    if (b.has_object_snap) begin
      px = longint'(b.snap_x);
      py = longint'(b.snap_y);
    end else begin
      if (grid_on && grid_sp != 0) begin
        px = grid_round(px, longint'(grid_sp));
        py = grid_round(py, longint'(grid_sp));
      end
      if (b.has_last_point) begin
        dx = px - lx;
        dy = py - ly;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ortho_on) begin
          if (ax >= ay) py = ly;
          else px = lx;
        end else if (polar_on) begin
          if (ax == 0 && ay == 0) begin
            px = lx;
            py = ly;
          end else begin
            s = ax * ax + ay * ay;
            sum2 = (ax + ay) * (ax + ay);
            x2 = 2 * ax * ax;
            y2 = 2 * ay * ay;
            if (sum2 < x2) begin
              l = root_round(s, 0);
              ox = dx < 0 ? -l : l;
              oy = 0;
            end else if (sum2 < y2) begin
              l = root_round(s, 0);
              ox = 0;
              oy = dy < 0 ? -l : l;
            end else begin
              l = root_round(s, 1);
              ox = dx < 0 ? -l : l;
              oy = dy < 0 ? -l : l;
            end
            px = lx + ox;
            py = ly + oy;
          end
        end
      end
    end
    px = clamp_coord(px, sat);
    py = clamp_coord(py, sat);
    r.result_x = px[31:0];
    r.result_y = py[31:0];
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fails++;
  endtask

  initial begin
    fails = 0;
    beats_checked = 0;
  end

  assign pending = expected_pts.size();

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      grid_on <= 0;
      grid_sp <= GRID_SP_RST;
      ortho_on <= 0;
      polar_on <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_GRID_ON: grid_on <= cfg_wdata[0];
          REG_GRID_SP: grid_sp <= cfg_wdata;
          REG_ORTHO:   ortho_on <= cfg_wdata[0];
          REG_POLAR:   polar_on <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_pts.push_back(predict_point(in_data));
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (expected_pts.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          e = expected_pts.pop_front();
          if (out_data.result_x !== e.result_x)
            report_mismatch($sformatf("result_x %h, want %h", out_data.result_x, e.result_x));
          if (out_data.result_y !== e.result_y)
            report_mismatch($sformatf("result_y %h, want %h", out_data.result_y, e.result_y));
          if (out_data.saturated !== e.saturated)
            report_mismatch($sformatf("saturated %b, want %b", out_data.saturated,
                                      e.saturated));
        end
      end
    end
  end
endmodule

@@ test/cad_pick_point_snap_tb.sv @@
module cad_pick_point_snap_tb;
  import cpps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0;
  logic          in_stall;
  in_t           in_data = '0;
  logic          out_valid;
  logic          out_stall = 0;
  out_t          out_data;
  logic          cfg_we = 0;
  reg_idx_t      cfg_idx = REG_GRID_ON;
  logic [GW-1:0] cfg_wdata = '0;
  int            fails, pending, beats_checked;
  int            beats_sent = 0;
  int            phases_run = 0;
  bit            no_idle = 0;

  always #6 clk = ~clk;

  cad_pick_point_snap uut (.*);

  cpps_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata), .fails(fails), .pending(pending),
    .beats_checked(beats_checked)
  );

  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 4);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1;
      end
      @(negedge clk);
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pick(in_t b);
    int n;
    bit st;
    n = no_idle ? 0 : $urandom_range(0, 4);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    in_data <= b;
    forever begin
      #1 st = in_stall;
      @(posedge clk);
      if (!st) break;
      @(negedge clk);
    end
    beats_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [GW-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_mode(bit g, logic [GW-1:0] sp, bit o, bit p);
    write_reg(REG_GRID_ON, GW'(g));
    write_reg(REG_GRID_SP, sp);
    write_reg(REG_ORTHO, GW'(o));
    write_reg(REG_POLAR, GW'(p));
    phases_run++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      3: return 32'($signed($urandom_range(0, 400)) - 200) << 16;
      4: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
      default: return $urandom & 32'h00ffffff;
    endcase
  endfunction

  function automatic in_t rand_pick();
    in_t b;
    logic [31:0] d;
    b.cursor_x = rand_coord();
    b.cursor_y = rand_coord();
    b.has_object_snap = ($urandom_range(0, 7) == 0);
    b.snap_x = $urandom;
    b.snap_y = $urandom;
    b.has_last_point = ($urandom_range(0, 4) != 0);
    b.last_x = $urandom_range(0, 2) == 0 ? $urandom : b.cursor_x + rand_coord() % 4096;
    b.last_y = $urandom_range(0, 2) == 0 ? $urandom : b.cursor_y + rand_coord() % 4096;
    if ($urandom_range(0, 9) == 0) begin
      d = rand_coord() % 4096;
      b.last_x = b.cursor_x - d;
      b.last_y = $urandom_range(0, 1) ? b.cursor_y - d : b.cursor_y + d;
    end
    return b;
  endfunction

  function automatic in_t mk(logic [31:0] cx, logic [31:0] cy, bit os, logic [31:0] sx,
                             logic [31:0] sy, bit hl, logic [31:0] lx, logic [31:0] ly);
    in_t b;
    b.cursor_x = cx;
    b.cursor_y = cy;
    b.has_object_snap = os;
    b.snap_x = sx;
    b.snap_y = sy;
    b.has_last_point = hl;
    b.last_x = lx;
    b.last_y = ly;
    return b;
  endfunction

  initial begin
    no_idle = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    send_pick(mk(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 0));
    send_pick(mk(1, 2, 1, 32'h80000000, 32'h7fffffff, 1, 5, 5));
    send_pick(mk(32'h00018000, 32'hfffe8000, 0, 0, 0, 0, 0, 0));
    drain();
    set_mode(1, 31'h7fffffff, 0, 0);
    send_pick(mk(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 0));
    send_pick(mk(32'h40000000, 32'hc0000000, 0, 0, 0, 1, 0, 0));
    drain();
    set_mode(1, 31'h00010000, 1, 0);
    send_pick(mk(32'h00018000, 32'hfffe8000, 0, 0, 0, 0, 0, 0));
    send_pick(mk(32'h00050000, 32'h00050000, 0, 0, 0, 1, 0, 0));
    send_pick(mk(32'h00030000, 32'h00070000, 0, 0, 0, 1, 0, 0));
    send_pick(mk(32'h7fffffff, 32'h7fffffff, 0, 0, 0, 1, 32'h80000000, 32'h80000000));
    drain();
    set_mode(0, 31'h0, 0, 1);
    send_pick(mk(100, 200, 0, 0, 0, 1, 100, 200));
    send_pick(mk(1000, 10, 0, 0, 0, 1, 0, 0));
    send_pick(mk(10, 1000, 0, 0, 0, 1, 0, 0));
    send_pick(mk(700, 650, 0, 0, 0, 1, 0, 0));
    send_pick(mk(32'h80000000, 32'h7fffffff, 0, 0, 0, 1, 32'h7fffffff, 32'h80000000));
    send_pick(mk(32'h7fffffff, 32'h7fffffff, 0, 0, 0, 1, 32'h80000000, 32'h80000000));
    send_pick(mk(-500, -20, 0, 0, 0, 1, 0, 0));
    send_pick(mk(5, 5, 1, 9, 9, 1, 0, 0));
    drain();
    set_mode(1, 31'h0, 1, 1);
    send_pick(mk(32'h00018000, 7, 0, 0, 0, 1, 0, 0));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_mode(0, 31'h00010000, 0, 0);
        1: set_mode(1, 31'h00010000, 0, 0);
        2: set_mode(1, 31'h7fffffff, 0, 1);
        3: set_mode(0, 31'h00000001, 1, 0);
        4: set_mode(1, 31'h00000001, 0, 1);
        5: set_mode(1, 31'h0, 1, 1);
        6: set_mode(0, GW'($urandom), 0, 1);
        7: set_mode(1, GW'($urandom_range(1, 1 << 20)), 1, 0);
        8: set_mode(1, GW'($urandom_range(1, 1 << 24)), 0, 1);
        default: set_mode(1'($urandom_range(0, 1)), GW'($urandom),
                          1'($urandom_range(0, 1)), 1);
      endcase
      no_idle = (ph == 4);
      repeat (70) send_pick(rand_pick());
      no_idle = 0;
      drain();
    end

    repeat (120) @(negedge clk);
    $display("Sent %0d picks over %0d register settings, checked %0d result beats.",
             beats_sent, phases_run, beats_checked);
    $display("Covered object snap, grid rounding, ortho, polar and saturation paths.");
    if (fails == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ files.f @@
src/cpps_pkg.sv
src/cpps_div_cell.sv
src/cpps_sq_cell.sv
src/cpps_sqrt_cell.sv
src/cad_pick_point_snap.sv
test/cpps_checker.sv
test/cad_pick_point_snap_tb.sv
